// ----- design/circular_double_ended_queue_defines.svh -----
// ----------------------------------------------------------------------------
// Circular double-ended queue: assertion macros
// Shared macros for the concurrent checks of the queue design.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Check sampled on the rising clock edge, switched off while reset is active.
`define CDQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check sampled on every rising clock edge, reset included.
`define CDQ_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/cdq_pkg.sv -----
// ----------------------------------------------------------------------------
// Circular double-ended queue package
// Sizes, action codes, controller states and slot arithmetic.
// ----------------------------------------------------------------------------
package cdq_pkg;

	localparam int DEPTH     = 64;
	localparam int PTR_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH);
	localparam int WORD_W    = 32;
	localparam int ENTRIES_W = 6;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		ACT_PUSH_FRONT = 2'd0,
		ACT_PUSH_BACK  = 2'd1,
		ACT_POP_FRONT  = 2'd2,
		ACT_POP_BACK   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_RESP = 3'b100
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;
		logic execute;
		logic commit;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic is_push;
		logic full;
		logic empty;
	} status_t;

	function automatic ptr_t slot_up(input ptr_t s);
		return (s == PTR_W'(DEPTH - 1)) ? '0 : ptr_t'(s + 1'b1);
	endfunction

	function automatic ptr_t slot_down(input ptr_t s);
		return (s == '0) ? PTR_W'(DEPTH - 1) : ptr_t'(s - 1'b1);
	endfunction

endpackage

// ----- design/cdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Circular double-ended queue controller
// Sequences capture, execution and result transfer of one action.
// ----------------------------------------------------------------------------
module cdq_ctrl import cdq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_RESP);

	// A push needs room, a pop needs a held word.
	assign cmd.capture = in_valid && in_ready;
	assign cmd.execute = (state_q == ST_EXEC);
	assign cmd.commit  = status.is_push ? !status.full : !status.empty;

endmodule

// ----- design/cdq_datapath.sv -----
// ----------------------------------------------------------------------------
// Circular double-ended queue datapath
// Word store, end pointers, held count and result registers.
// ----------------------------------------------------------------------------
module cdq_datapath import cdq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output status_t                  status,
	input  logic [1:0]               action,
	input  logic signed [WORD_W-1:0] push_value,
	output logic                     ok,
	output logic signed [WORD_W-1:0] popped_value,
	output logic [ENTRIES_W-1:0]     entries
);

	logic [WORD_W-1:0] mem [DEPTH];

	action_t           action_q;
	logic [WORD_W-1:0] value_q;
	ptr_t              front_q;
	ptr_t              back_q;
	cnt_t              count_q;
	logic              ok_q;
	logic              is_pop_q;
	logic [WORD_W-1:0] rd_data_q;

	logic wr_en;
	ptr_t wr_addr;
	logic rd_en;
	ptr_t rd_addr;
	logic do_it;

	assign status.is_push = (action_q == ACT_PUSH_FRONT) || (action_q == ACT_PUSH_BACK);
	assign status.full    = (count_q == CNT_W'(DEPTH - 1));
	assign status.empty   = (count_q == '0);

	assign do_it = cmd.execute && cmd.commit;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = front_q;
		rd_en   = 1'b0;
		rd_addr = slot_up(front_q);
		case (action_q)
			ACT_PUSH_FRONT: begin
				wr_en   = do_it;
				wr_addr = front_q;
			end
			ACT_PUSH_BACK: begin
				wr_en   = do_it;
				wr_addr = back_q;
			end
			ACT_POP_FRONT: begin
				rd_en   = do_it;
				rd_addr = slot_up(front_q);
			end
			ACT_POP_BACK: begin
				rd_en   = do_it;
				rd_addr = slot_down(back_q);
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= value_q;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= action_t'(action);
			value_q  <= push_value;
		end
		if (cmd.execute) begin
			ok_q     <= cmd.commit;
			is_pop_q <= !status.is_push;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= PTR_W'(1 % DEPTH);
			count_q <= '0;
		end else if (do_it) begin
			case (action_q)
				ACT_PUSH_FRONT: front_q <= slot_down(front_q);
				ACT_PUSH_BACK:  back_q  <= slot_up(back_q);
				ACT_POP_FRONT:  front_q <= slot_up(front_q);
				ACT_POP_BACK:   back_q  <= slot_down(back_q);
				default:        front_q <= front_q;
			endcase
			count_q <= status.is_push ? cnt_t'(count_q + 1'b1) : cnt_t'(count_q - 1'b1);
		end
	end

	assign ok           = ok_q;
	assign popped_value = (ok_q && is_pop_q) ? rd_data_q : '0;
	assign entries      = ENTRIES_W'(count_q);

endmodule

// ----- design/circular_double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// Circular double-ended queue
// Signed 32-bit words pushed and popped at either end of a circular store.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Payload
//  -------  ---------------------  -----------------------------------------
//  input    in_valid / in_ready    action, push_value
//  output   out_valid / out_ready  ok, popped_value, entries
//
// Each action passes through the idle state, whose cycle ends in its input
// transfer, an execute state, and the respond state in which its result is
// offered. The execute state writes or reads the word store, whose read data
// is registered. A new action is taken in the cycle after the previous result
// transfer completes, so a stalled output holds off the input side, and the
// queue takes no new action until the last result has been transferred.
// Reset puts the front pointer at slot 0, the back pointer at slot 1 and the
// held count at zero; the word store itself is not cleared.
//
`include "circular_double_ended_queue_defines.svh"

module circular_double_ended_queue import cdq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               action,
	input  logic signed [WORD_W-1:0] push_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     ok,
	output logic signed [WORD_W-1:0] popped_value,
	output logic [ENTRIES_W-1:0]     entries
);

	// Commands go from the controller to the datapath; the datapath reports
	// whether the captured action is a push and whether the store is full or
	// empty, which decides if the action is carried out.
	cmd_t    cmd;
	status_t status;

	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds the store, both end pointers and the held count, and
	// keeps the result registered until the output transfer.
	cdq_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.action       (action),
		.push_value   (push_value),
		.ok           (ok),
		.popped_value (popped_value),
		.entries      (entries)
	);

	// Only one action is in flight, so the two sides are never open together.
	// The state register is unknown before the first reset edge, and only a
	// known high on both sides counts as a violation.
	`CDQ_ASSERT_ALWAYS(a_one_in_flight, !(in_ready === 1'b1 && out_valid === 1'b1), "input and output open together")
	// Every input transfer produces a result offered once the execute state has passed.
	`CDQ_ASSERT(a_result_follows, (in_valid && in_ready) |=> ##1 out_valid, "result did not appear")
	// A refused action or a push never returns a word.
	`CDQ_ASSERT(a_refused_zero, (out_valid && !ok) |-> (popped_value == '0), "refused action returned data")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular double-ended queue testbench
// Drives push and pop actions at both ends of the queue, with random gaps on
// the input side and random stalls on the result side. A shadow model of the
// queue predicts each result, and every result transfer is checked field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
	import cdq_pkg::*;

	// One action waiting to be driven, with the idle cycles that precede it.
	// A settle action is held back until every earlier result has come out.
	typedef struct {
		action_t                   act;
		logic signed [WORD_W-1:0]  word;
		int                        gap;
		bit                        settle;
	} deque_cmd_t;

	// The result that one action should produce.
	typedef struct {
		logic                      ok;
		logic signed [WORD_W-1:0]  popped;
		logic [ENTRIES_W-1:0]      entries;
	} deque_reply_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid;
	logic                     in_ready;
	logic [1:0]               action;
	logic signed [WORD_W-1:0] push_value;
	logic                     out_valid;
	logic                     out_ready;
	logic                     ok;
	logic signed [WORD_W-1:0] popped_value;
	logic [ENTRIES_W-1:0]     entries;

	// Actions still to be driven, filled once at time zero.
	deque_cmd_t   queued_actions[$];
	// Replies predicted for accepted actions, oldest first.
	deque_reply_t replies_due[$];

	// Shadow copy of the queue state. Slots are only read after a push wrote
	// them, so the words need no reset value.
	logic signed [WORD_W-1:0] shadow_words[DEPTH];
	ptr_t                     shadow_front;
	ptr_t                     shadow_back;
	int                       shadow_held;

	int mismatch_count = 0;
	int replies_seen = 0;
	bit sender_quiet = 1'b0;

	// Driver bookkeeping: actions accepted whose results have not yet been
	// transferred, and idle cycles left before the next action goes out.
	int in_flight;
	int gap_left;
	// Monitor bookkeeping: stall cycles left on the result side.
	int stall_left;

	circular_double_ended_queue u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.push_value   (push_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.ok           (ok),
		.popped_value (popped_value),
		.entries      (entries)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Slot arithmetic of the circular store: the front end grows toward lower
	// slots and the back end toward higher ones, both wrapping around.
	function automatic ptr_t slot_after(input ptr_t p);
		return ptr_t'((int'(p) + 1) % DEPTH);
	endfunction

	function automatic ptr_t slot_before(input ptr_t p);
		return ptr_t'((int'(p) + DEPTH - 1) % DEPTH);
	endfunction

	// Applies one action to the shadow queue and returns the reply it should
	// produce. A push is refused once DEPTH-1 words are held, so one slot
	// always separates the two ends; a pop from an empty queue is refused.
	// Refused actions leave the state alone and report a zero word.
	function automatic deque_reply_t deque_apply(input action_t act,
			input logic signed [WORD_W-1:0] word);
		deque_reply_t r;
		r.ok = 1'b0;
		r.popped = '0;
		case (act)
			ACT_PUSH_FRONT: begin
				if (shadow_held < DEPTH - 1) begin
					shadow_words[shadow_front] = word;
					shadow_front = slot_before(shadow_front);
					shadow_held++;
					r.ok = 1'b1;
				end
			end
			ACT_PUSH_BACK: begin
				if (shadow_held < DEPTH - 1) begin
					shadow_words[shadow_back] = word;
					shadow_back = slot_after(shadow_back);
					shadow_held++;
					r.ok = 1'b1;
				end
			end
			ACT_POP_FRONT: begin
				// The front pointer names the free slot, so the word sits
				// one slot above it.
				if (shadow_held > 0) begin
					shadow_front = slot_after(shadow_front);
					r.popped = shadow_words[shadow_front];
					shadow_held--;
					r.ok = 1'b1;
				end
			end
			default: begin
				if (shadow_held > 0) begin
					shadow_back = slot_before(shadow_back);
					r.popped = shadow_words[shadow_back];
					shadow_held--;
					r.ok = 1'b1;
				end
			end
		endcase
		r.entries = ENTRIES_W'(shadow_held);
		return r;
	endfunction

	// Mostly full-range random words, with the sign extremes and the values
	// around zero showing up often.
	function automatic logic signed [WORD_W-1:0] pick_word();
		case ($urandom_range(15))
			0: return {1'b1, {(WORD_W-1){1'b0}}};
			1: return {1'b0, {(WORD_W-1){1'b1}}};
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_cmd(input action_t act, input logic signed [WORD_W-1:0] word,
			input bit settle);
		deque_cmd_t c;
		c.act = act;
		c.word = word;
		c.gap = sender_quiet ? 0 : $urandom_range(9);
		c.settle = settle;
		queued_actions.push_back(c);
	endtask

	// Driver. The next action is offered as soon as the previous transfer is
	// done and its idle cycles have passed. The in-flight count is kept from
	// the handshakes sampled at this edge, so the settle hold-off does not
	// depend on the order in which the clocked blocks run.
	always @(posedge clk or negedge arst_n) begin
		deque_cmd_t c;
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= ACT_PUSH_FRONT;
			push_value <= '0;
			in_flight = 0;
			gap_left = -1;
		end else begin
			if (in_valid && in_ready)
				in_flight++;
			if (out_valid && out_ready)
				in_flight--;
			// While an offer is still waiting for ready, valid and the
			// payload are left untouched.
			if (!in_valid || in_ready) begin
				if (queued_actions.size() == 0) begin
					in_valid <= 1'b0;
				end else begin
					if (gap_left < 0)
						gap_left = queued_actions[0].gap;
					if (gap_left > 0) begin
						gap_left--;
						in_valid <= 1'b0;
					end else if (queued_actions[0].settle && in_flight != 0) begin
						in_valid <= 1'b0;
					end else begin
						c = queued_actions.pop_front();
						action <= c.act;
						push_value <= c.word;
						in_valid <= 1'b1;
						gap_left = -1;
					end
				end
			end
		end
	end

	// Monitor. It watches both channels: every input transfer is run through
	// the shadow queue and its reply is stored, and every result transfer is
	// checked against the oldest stored reply. After each result the ready
	// line drops for a random number of cycles, except in quiet stretches.
	always @(posedge clk or negedge arst_n) begin
		deque_reply_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
			shadow_front = '0;
			shadow_back = ptr_t'(1 % DEPTH);
			shadow_held = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					$error("result transfer with no action outstanding");
					mismatch_count++;
				end else begin
					want = replies_due.pop_front();
					if (ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, ok);
						mismatch_count++;
					end
					if (popped_value !== want.popped) begin
						$error("popped_value: expected %0d, got %0d",
							want.popped, popped_value);
						mismatch_count++;
					end
					if (entries !== want.entries) begin
						$error("entries: expected %0d, got %0d", want.entries, entries);
						mismatch_count++;
					end
				end
				replies_seen++;
				stall_left = ((replies_seen / 80) % 4 == 1) ? 0 : $urandom_range(9);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			if (in_valid && in_ready)
				replies_due.push_back(deque_apply(action_t'(action), push_value));
			out_ready <= (stall_left == 0);
		end
	end

	// Stimulus and end of run.
	initial begin
		int made;
		int blk;
		int len;
		int push_pct;
		action_t act;

		// Directed part: refused pops on an empty queue, the word extremes
		// through both ends, a push at one end popped from the other, and a
		// drain back to empty.
		queue_cmd(ACT_POP_FRONT, 32'sd7, 1'b0);
		queue_cmd(ACT_POP_BACK, -32'sd7, 1'b0);
		queue_cmd(ACT_PUSH_FRONT, {1'b1, {(WORD_W-1){1'b0}}}, 1'b0);
		queue_cmd(ACT_PUSH_BACK, {1'b0, {(WORD_W-1){1'b1}}}, 1'b0);
		queue_cmd(ACT_PUSH_FRONT, '0, 1'b0);
		queue_cmd(ACT_PUSH_BACK, '1, 1'b0);
		queue_cmd(ACT_POP_FRONT, 32'sh1234_5678, 1'b0);
		queue_cmd(ACT_POP_BACK, '1, 1'b0);
		queue_cmd(ACT_POP_FRONT, '0, 1'b0);
		queue_cmd(ACT_POP_BACK, '0, 1'b0);
		queue_cmd(ACT_POP_FRONT, '1, 1'b0);
		queue_cmd(ACT_PUSH_BACK, 32'sd1, 1'b0);
		queue_cmd(ACT_POP_FRONT, '0, 1'b0);
		queue_cmd(ACT_PUSH_FRONT, 32'sh5555_5555, 1'b0);
		queue_cmd(ACT_POP_BACK, '0, 1'b0);
		queue_cmd(ACT_PUSH_BACK, 32'shAAAA_AAAA, 1'b0);
		queue_cmd(ACT_PUSH_FRONT, pick_word(), 1'b0);
		queue_cmd(ACT_POP_BACK, '0, 1'b0);
		queue_cmd(ACT_POP_BACK, '0, 1'b0);
		queue_cmd(ACT_POP_BACK, '0, 1'b0);

		// Random part, in blocks that lean toward pushes, toward pops, or
		// neither. Push-heavy blocks run the queue into the full case and
		// pop-heavy ones back to empty, with the pointers wrapping on the way.
		// Some blocks send back to back, and every fourth block first waits
		// for the queue's results to drain.
		made = 0;
		blk = 0;
		while (made < 900) begin
			case (blk % 3)
				0: push_pct = 85;
				1: push_pct = 15;
				default: push_pct = 50;
			endcase
			sender_quiet = (blk % 5 == 3);
			len = $urandom_range(60, 120);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(99) < push_pct)
					act = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
				else
					act = $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
				queue_cmd(act, pick_word(), (i == 0) && (blk % 4 == 1));
			end
			made += len;
			blk++;
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Checked on the falling edge, after all clocked updates have settled.
		while (queued_actions.size() != 0 || in_valid || replies_due.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Timeout, far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
